// File: rtl/kmc_pkg.sv
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared types, constants and helpers for the k-mer occurrence counter.
// ----------------------------------------------------------------------------
package kmc_pkg;

    localparam int MAX_KMER_BASES = 8;
    localparam int SEQ_SLOTS      = 16;
    localparam int COUNT_BITS     = 16;

    localparam int CODE_BITS   = 2 * MAX_KMER_BASES;
    localparam int TABLE_DEPTH = SEQ_SLOTS << CODE_BITS;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int SH_BITS     = (CODE_BITS > 2) ? $clog2(CODE_BITS) : 1;

    // widths fixed by the item fields
    localparam int LEN_BITS   = 4;
    localparam int SLOT_BITS  = 4;
    localparam int QCODE_BITS = 16;
    localparam int VALUE_BITS = 16;
    localparam int SEEN_BITS  = $clog2(MAX_KMER_BASES + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic REQ_BASE  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [0:0] {
        CFG_MIN_LEN = 1'b0,
        CFG_MAX_LEN = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                  req_type;
        logic [7:0]            base_char;
        logic                  first_of_seq;
        logic [SLOT_BITS-1:0]  seq_slot;
        logic [QCODE_BITS-1:0] query_code;
    } t_kmc_in;

    typedef struct packed {
        logic [VALUE_BITS-1:0] count_value;
        logic                  count_saturated;
    } t_kmc_out;

    // request into the count table
    typedef struct packed {
        logic                 rd_en;
        logic                 incr;
        logic [ADDR_BITS-1:0] addr;
    } t_tbl_req;

    // status out of the count table
    typedef struct packed {
        logic                  busy;
        logic [COUNT_BITS-1:0] rd_data;
    } t_tbl_stat;

    // window state and counted length range
    typedef struct packed {
        logic [CODE_BITS-1:0] window;
        logic [LEN_BITS-1:0]  lo;
        logic [LEN_BITS-1:0]  hi;
    } t_win_info;

    function automatic logic [1:0] base_code(input logic [7:0] ch);
        logic [1:0] code;
        unique case (ch)
            8'h41:   code = 2'd3;  // A
            8'h43:   code = 2'd1;  // C
            8'h47:   code = 2'd2;  // G
            default: code = 2'd0;  // T and anything else
        endcase
        return code;
    endfunction

endpackage

// File: rtl/kmer_occurrence_counter.sv
// ----------------------------------------------------------------------------
// kmer_occurrence_counter
// Counts k-mers of a DNA base stream into a per-slot table; answers queries.
// ----------------------------------------------------------------------------
// After reset the block sweeps the count memory to zero, one entry per cycle,
// over all 1,048,576 entries; no transaction is accepted on the input channel
// until the sweep is done (configuration writes are taken). A base transaction
// then occupies the block for one counter update per k-mer length counted
// (at most 8 lengths): the simple dual-port count memory does one
// read-modify-write per length, pipelined with forwarding between back-to-back
// updates of the same counter. A query's read data is registered in the count
// memory, then loaded into the output register once that register is free or
// being taken; the next transaction is accepted while a query result waits to
// be taken, and a second query's result is held until the first is taken.
module kmer_occurrence_counter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  kmc_pkg::t_kmc_in             i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output kmc_pkg::t_kmc_out            o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  kmc_pkg::t_cfg_idx            i_cfg_index,
    input  logic [kmc_pkg::LEN_BITS-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_COUNT  = 4'b0100,
        ST_RESULT = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    logic [kmc_pkg::LEN_BITS-1:0]    r_min_len;
    logic [kmc_pkg::LEN_BITS-1:0]    r_max_len;
    logic [kmc_pkg::LEN_BITS-1:0]    r_len, n_len;
    logic [kmc_pkg::SLOT_BITS-1:0]   r_slot, n_slot;
    logic                            r_zero, n_zero;
    logic                            r_out_valid;
    kmc_pkg::t_kmc_out               r_out;

    logic                            in_acc;
    logic                            slot_ok;
    logic                            win_en;
    logic                            out_load;
    logic [kmc_pkg::SH_BITS-1:0]     sh;
    logic [kmc_pkg::CODE_BITS-1:0]   kmer_code;
    logic [kmc_pkg::CODE_BITS-1:0]   qcode;
    kmc_pkg::t_win_info              win;
    kmc_pkg::t_tbl_req               tbl_req;
    kmc_pkg::t_tbl_stat              tbl_stat;

    kmc_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (win_en),
        .i_base_char (i_in_data.base_char),
        .i_first     (i_in_data.first_of_seq),
        .i_min_len   (r_min_len),
        .i_max_len   (r_max_len),
        .o_info      (win)
    );

    kmc_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .o_stat  (tbl_stat)
    );

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= kmc_pkg::LEN_BITS'(8);
            r_max_len <= kmc_pkg::LEN_BITS'(8);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                kmc_pkg::CFG_MIN_LEN: r_min_len <= i_cfg_data;
                kmc_pkg::CFG_MAX_LEN: r_max_len <= i_cfg_data;
                default:              ;
            endcase
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid & o_in_ready;
    assign slot_ok    = int'(i_in_data.seq_slot) < kmc_pkg::SEQ_SLOTS;
    assign win_en     = in_acc && (i_in_data.req_type == kmc_pkg::REQ_BASE);
    assign out_load   = (r_state == ST_RESULT) && (!r_out_valid || i_out_ready);

    always_comb begin
        sh        = kmc_pkg::SH_BITS'(2 * (kmc_pkg::MAX_KMER_BASES - int'(r_len)));
        kmer_code = win.window >> sh;
        qcode     = kmc_pkg::CODE_BITS'(i_in_data.query_code);
    end

    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_slot       = r_slot;
        n_zero       = r_zero;
        tbl_req      = '0;
        unique case (r_state)
            ST_CLEAR: begin
                if (!tbl_stat.busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_slot = i_in_data.seq_slot;
                    if (i_in_data.req_type == kmc_pkg::REQ_QUERY) begin
                        n_zero        = !slot_ok;
                        tbl_req.rd_en = slot_ok;
                        tbl_req.addr  = kmc_pkg::ADDR_BITS'({i_in_data.seq_slot, qcode});
                        n_state       = ST_RESULT;
                    end else if (slot_ok) begin
                        n_len   = win.lo;
                        n_state = ST_COUNT;
                    end
                end
            end
            ST_COUNT: begin
                // one counter update per length, lo up to hi
                if (r_len <= win.hi) begin
                    tbl_req.rd_en = 1'b1;
                    tbl_req.incr  = 1'b1;
                    tbl_req.addr  = kmc_pkg::ADDR_BITS'({r_slot, kmer_code});
                    n_len         = r_len + kmc_pkg::LEN_BITS'(1);
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_RESULT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len  <= n_len;
        r_slot <= n_slot;
        r_zero <= n_zero;
        if (out_load) begin
            if (r_zero) begin
                r_out <= '0;
            end else begin
                r_out.count_value     <= kmc_pkg::VALUE_BITS'(tbl_stat.rd_data);
                r_out.count_saturated <= (tbl_stat.rd_data == kmc_pkg::COUNT_MAX);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // no transaction is taken while the memory is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !tbl_stat.busy)
        else $error("input accepted during memory clear");

    // counter updates only come from the counting sequence with a legal length
    a_incr_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tbl_req.rd_en && tbl_req.incr) |->
            (r_state == ST_COUNT) && (r_len != '0)
            && (int'(r_len) <= kmc_pkg::MAX_KMER_BASES))
        else $error("counter update outside counting sequence");

    // a result appears only after a query was waiting for it
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_RESULT))
        else $error("result without pending query");

    // a pending result is not lost when a new query completes
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("pending result dropped");

endmodule

// File: rtl/kmc_window.sv
// ----------------------------------------------------------------------------
// kmc_window
// Recent-base window, base count and the range of k-mer lengths to count.
// ----------------------------------------------------------------------------
module kmc_window (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [7:0]                   i_base_char,
    input  logic                         i_first,
    input  logic [kmc_pkg::LEN_BITS-1:0] i_min_len,
    input  logic [kmc_pkg::LEN_BITS-1:0] i_max_len,
    output kmc_pkg::t_win_info           o_info
);

    logic [kmc_pkg::CODE_BITS-1:0] r_window, n_window;
    logic [kmc_pkg::SEEN_BITS-1:0] r_seen, n_seen;
    logic [kmc_pkg::CODE_BITS-1:0] prior;
    logic [kmc_pkg::SEEN_BITS-1:0] seen_base;
    logic [kmc_pkg::LEN_BITS-1:0]  hi_cfg;
    logic [kmc_pkg::LEN_BITS-1:0]  seen_ext;

    always_comb begin
        prior     = i_first ? '0 : r_window;
        seen_base = i_first ? '0 : r_seen;
        // newest base enters at the top
        n_window  = (prior >> 2)
                  | (kmc_pkg::CODE_BITS'(kmc_pkg::base_code(i_base_char))
                     << (kmc_pkg::CODE_BITS - 2));
        if (int'(seen_base) < kmc_pkg::MAX_KMER_BASES) begin
            n_seen = seen_base + kmc_pkg::SEEN_BITS'(1);
        end else begin
            n_seen = seen_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_seen   <= '0;
        end else if (i_en) begin
            r_window <= n_window;
            r_seen   <= n_seen;
        end
    end

    always_comb begin
        seen_ext = kmc_pkg::LEN_BITS'(r_seen);
        if (int'(i_max_len) > kmc_pkg::MAX_KMER_BASES) begin
            hi_cfg = kmc_pkg::LEN_BITS'(kmc_pkg::MAX_KMER_BASES);
        end else begin
            hi_cfg = i_max_len;
        end
        o_info.window = r_window;
        o_info.lo     = (i_min_len == '0) ? kmc_pkg::LEN_BITS'(1) : i_min_len;
        o_info.hi     = (hi_cfg > seen_ext) ? seen_ext : hi_cfg;
    end

endmodule

// File: rtl/kmc_table.sv
// ----------------------------------------------------------------------------
// kmc_table
// Count memory with read-modify-write, write forwarding and a clear sweep.
// ----------------------------------------------------------------------------
module kmc_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kmc_pkg::t_tbl_req  i_req,
    output kmc_pkg::t_tbl_stat o_stat
);

    logic [kmc_pkg::COUNT_BITS-1:0] r_mem [kmc_pkg::TABLE_DEPTH];

    logic                           r_clearing;
    logic [kmc_pkg::ADDR_BITS-1:0]  r_clr_addr;
    logic [kmc_pkg::COUNT_BITS-1:0] r_q;
    logic                           r_fwd;
    logic [kmc_pkg::COUNT_BITS-1:0] r_fwd_data;
    logic                           r_wb_en;
    logic [kmc_pkg::ADDR_BITS-1:0]  r_wb_addr;

    logic                           wr_en;
    logic [kmc_pkg::ADDR_BITS-1:0]  wr_addr;
    logic [kmc_pkg::COUNT_BITS-1:0] wr_data;
    logic [kmc_pkg::COUNT_BITS-1:0] rd_data;
    logic [kmc_pkg::COUNT_BITS-1:0] inc_data;

    always_comb begin
        // a write on the same edge as the read is not seen by the memory read
        rd_data  = r_fwd ? r_fwd_data : r_q;
        inc_data = (rd_data == kmc_pkg::COUNT_MAX) ? rd_data
                 : rd_data + kmc_pkg::COUNT_BITS'(1);
        wr_en    = r_clearing | r_wb_en;
        wr_addr  = r_clearing ? r_clr_addr : r_wb_addr;
        wr_data  = r_clearing ? '0 : inc_data;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_req.rd_en) begin
            r_q        <= r_mem[i_req.addr];
            r_fwd_data <= wr_data;
            r_wb_addr  <= i_req.addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_wb_en    <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (r_clearing) begin
                if (r_clr_addr == kmc_pkg::ADDR_BITS'(kmc_pkg::TABLE_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + kmc_pkg::ADDR_BITS'(1);
            end
            r_wb_en <= i_req.rd_en & i_req.incr;
            if (i_req.rd_en) begin
                r_fwd <= wr_en && (wr_addr == i_req.addr);
            end
        end
    end

    assign o_stat.busy    = r_clearing;
    assign o_stat.rd_data = rd_data;

endmodule
